>>> src/swc_pkg.sv
// Shared constants, codes and types of the sliding window correlation block.
`timescale 1ns / 1ps
package swc_pkg;

	// Sample and count widths; a window never exceeds 511 pairs.
	localparam int SB     = 16;
	localparam int CNT_W  = 9;
	localparam int CFG_W  = 9;
	localparam int IDX_W  = 2;
	localparam int SUM_W  = SB + CNT_W;
	localparam int SQ_W   = 2 * SB + CNT_W;
	// Shared multiplier limb and the widths of the wide products.
	localparam int LIMB_W = SUM_W - 1;
	localparam int MAG_W  = 2 * LIMB_W;
	localparam int PROD_W = 2 * MAG_W;
	localparam int ACC_W  = PROD_W + 3;
	// Result bits and the widths of the root search.
	localparam int QB     = 16;
	localparam int M_W    = PROD_W + 2 * QB;
	localparam int TRY_W  = M_W + 3;
	localparam int STEP_W = 5;

	localparam int DEF_MAX_WINDOW = 256;

	// Sequencer step limits.
	localparam logic [STEP_W-1:0] UPD_LAST  = STEP_W'(6);
	localparam logic [STEP_W-1:0] MAC_LAST  = STEP_W'(26);
	localparam logic [STEP_W-1:0] SRCH_LAST = STEP_W'(QB - 1);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_WINDOW  = 2'd0;
	localparam logic [IDX_W-1:0] REG_PARTIAL = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN     = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_NONE  = 2'd0;
	localparam logic [1:0] STAT_VALID = 2'd1;
	localparam logic [1:0] STAT_FLAT  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_UPD, ST_MAC, ST_SINIT, ST_TRY, ST_DEC, ST_FIN
	} state_t;

	// Square terms of the running sums: old pair out, new pair in.
	typedef enum logic [2:0] {
		SQ_OXX, SQ_OYY, SQ_OXY, SQ_NXX, SQ_NYY, SQ_NXY
	} sq_op_t;

	// Partial products issued to the shared multiplier.
	typedef enum logic [4:0] {
		MO_N_XXL, MO_N_XXH, MO_SX_SX,
		MO_N_YYL, MO_N_YYH, MO_SY_SY,
		MO_N_XYL, MO_N_XYH, MO_SX_SY,
		MO_P_LL, MO_P_LH, MO_P_HL, MO_P_HH,
		MO_M_LL, MO_M_LH, MO_M_HL, MO_M_HH
	} mac_op_t;

	typedef enum logic [2:0] {
		SD_VX, SD_VY, SD_NUM, SD_P, SD_M
	} store_t;

	typedef struct packed {
		logic    load;
		logic    rd;
		logic    upd_lin;
		logic    sq_en;
		sq_op_t  sq_op;
		logic    mac_en;
		mac_op_t mac_op;
		logic    store_en;
		store_t  store_dst;
		logic    srch_init;
		logic    srch_try;
		logic    srch_dec;
		logic    res_load;
	} swc_cmd_t;

	typedef struct packed {
		logic report;
		logic out_free;
	} swc_sts_t;

endpackage

>>> src/swc_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module swc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/swc_ctrl.sv
// Sequencer of the sliding window correlation block.
`timescale 1ns / 1ps
module swc_ctrl import swc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  swc_sts_t sts,
	output swc_cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	// State and step registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				step_d  = '0;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_lin = (step_q == '0);
				if (step_q < UPD_LAST) begin
					cmd.sq_en = 1'b1;
					cmd.sq_op = sq_op_t'(step_q[2:0]);
				end
				if (step_q == UPD_LAST) begin
					step_d  = '0;
					state_d = sts.report ? ST_MAC : ST_FIN;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_MAC: begin
				cmd.mac_en = 1'b1;
				unique case (step_q)
					5'd0:  cmd.mac_op = MO_N_XXL;
					5'd1:  cmd.mac_op = MO_N_XXH;
					5'd2:  cmd.mac_op = MO_SX_SX;
					5'd5:  cmd.mac_op = MO_N_YYL;
					5'd6:  cmd.mac_op = MO_N_YYH;
					5'd7:  cmd.mac_op = MO_SY_SY;
					5'd10: cmd.mac_op = MO_N_XYL;
					5'd11: cmd.mac_op = MO_N_XYH;
					5'd12: cmd.mac_op = MO_SX_SY;
					5'd15: cmd.mac_op = MO_P_LL;
					5'd16: cmd.mac_op = MO_P_LH;
					5'd17: cmd.mac_op = MO_P_HL;
					5'd18: cmd.mac_op = MO_P_HH;
					5'd21: cmd.mac_op = MO_M_LL;
					5'd22: cmd.mac_op = MO_M_LH;
					5'd23: cmd.mac_op = MO_M_HL;
					5'd24: cmd.mac_op = MO_M_HH;
					default: cmd.mac_en = 1'b0;
				endcase
				// Each group's store comes after its last product has passed the product register and been accumulated.
				unique case (step_q)
					5'd4: begin
						cmd.store_en  = 1'b1;
						cmd.store_dst = SD_VX;
					end
					5'd9: begin
						cmd.store_en  = 1'b1;
						cmd.store_dst = SD_VY;
					end
					5'd14: begin
						cmd.store_en  = 1'b1;
						cmd.store_dst = SD_NUM;
					end
					5'd20: begin
						cmd.store_en  = 1'b1;
						cmd.store_dst = SD_P;
					end
					5'd26: begin
						cmd.store_en  = 1'b1;
						cmd.store_dst = SD_M;
					end
					default: cmd.store_en = 1'b0;
				endcase
				if (step_q == MAC_LAST) begin
					step_d  = '0;
					state_d = ST_SINIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SINIT: begin
				cmd.srch_init = 1'b1;
				step_d        = '0;
				state_d       = ST_TRY;
			end
			ST_TRY: begin
				cmd.srch_try = 1'b1;
				state_d      = ST_DEC;
			end
			ST_DEC: begin
				cmd.srch_dec = 1'b1;
				if (step_q == SRCH_LAST) begin
					state_d = ST_FIN;
				end else begin
					step_d  = step_q + 1'b1;
					state_d = ST_TRY;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> src/swc_dp.sv
// Datapath: history, running sums, shared multiplier, root search, result beat.
`timescale 1ns / 1ps
module swc_dp import swc_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swc_cmd_t             cmd,
	output swc_sts_t             sts,
	input  logic signed [SB-1:0] x_sample,
	input  logic signed [SB-1:0] y_sample,
	input  logic                 series_start,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [QB-1:0] correlation,
	output logic [1:0]           status
);

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int WCAP  = (MAX_WINDOW > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_WINDOW;
	localparam int AW    = ((PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W) + 1;
	localparam logic [CNT_W-1:0] WCAP_C = CNT_W'(WCAP);

	// Configuration.
	logic [CFG_W-1:0] wlen_q, minsmp_q;
	logic             partial_q;
	logic             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= CFG_W'(20);
			partial_q <= 1'b0;
			minsmp_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW:  wlen_q    <= cfg_data;
				REG_PARTIAL: partial_q <= cfg_data[0];
				REG_MIN:     minsmp_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Effective window, clamped to 1..MAX_WINDOW and to at most 511.
	logic [CNT_W-1:0] weff;
	assign weff = (wlen_q == '0) ? CNT_W'(1) : ((wlen_q > WCAP_C) ? WCAP_C : wlen_q);

	// Input pair and window state.
	logic signed [SB-1:0]    x_q, y_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PTR_W-1:0]        wp_q;
	logic                    full_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;
	logic signed [SQ_W-1:0]  sxx_q, syy_q, sxy_q;
	logic                    clr;

	assign clr = (cmd.load & series_start) | (cfg_we & (cfg_index == REG_WINDOW));

	// Oldest pair of the window sits w entries behind the write pointer.
	logic [AW-1:0]    wp_ext, w_ext, diff;
	logic [PTR_W-1:0] old_idx;
	assign wp_ext  = AW'(wp_q);
	assign w_ext   = AW'(weff);
	assign diff    = (wp_ext >= w_ext) ? wp_ext - w_ext : wp_ext + AW'(MAX_WINDOW) - w_ext;
	assign old_idx = diff[PTR_W-1:0];

	logic [2*SB-1:0] rdata;

	swc_ram #(
		.WIDTH(2 * SB),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (cmd.upd_lin),
		.waddr(wp_q),
		.wdata({x_q, y_q}),
		.re   (cmd.rd),
		.raddr(old_idx),
		.rdata(rdata)
	);

	// Dropped pair, zero while the window is still filling.
	logic signed [SB-1:0] ox, oy;
	assign ox = full_q ? $signed(rdata[2*SB-1:SB]) : '0;
	assign oy = full_q ? $signed(rdata[SB-1:0]) : '0;

	// Square-term multiplier operands.
	logic signed [SB-1:0]   sa, sb_v;
	logic signed [2*SB-1:0] sqprod_s1;
	sq_op_t                 sqop_s1;
	logic                   sqvld_s1;
	logic signed [SQ_W-1:0] sqext;

	always_comb begin
		sa   = ox;
		sb_v = ox;
		case (cmd.sq_op)
			SQ_OXX: begin
				sa   = ox;
				sb_v = ox;
			end
			SQ_OYY: begin
				sa   = oy;
				sb_v = oy;
			end
			SQ_OXY: begin
				sa   = ox;
				sb_v = oy;
			end
			SQ_NXX: begin
				sa   = x_q;
				sb_v = x_q;
			end
			SQ_NYY: begin
				sa   = y_q;
				sb_v = y_q;
			end
			SQ_NXY: begin
				sa   = x_q;
				sb_v = y_q;
			end
			default: ;
		endcase
	end

	assign sqext = SQ_W'(sqprod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqvld_s1 <= 1'b0;
		end else begin
			sqvld_s1 <= cmd.sq_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sqprod_s1 <= sa * sb_v;
			sqop_s1   <= cmd.sq_op;
		end
		if (cmd.load) begin
			x_q <= x_sample;
			y_q <= y_sample;
		end
	end

	// Window control and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wp_q   <= '0;
			full_q <= 1'b0;
			sx_q   <= '0;
			sy_q   <= '0;
			sxx_q  <= '0;
			syy_q  <= '0;
			sxy_q  <= '0;
		end else if (clr) begin
			cnt_q <= '0;
			wp_q  <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else begin
			if (cmd.rd) begin
				full_q <= (cnt_q >= weff);
			end
			if (cmd.upd_lin) begin
				cnt_q <= full_q ? weff : cnt_q + 1'b1;
				wp_q  <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
				sx_q  <= sx_q - SUM_W'(ox) + SUM_W'(x_q);
				sy_q  <= sy_q - SUM_W'(oy) + SUM_W'(y_q);
			end
			if (sqvld_s1) begin
				case (sqop_s1)
					SQ_OXX:  sxx_q <= sxx_q - sqext;
					SQ_OYY:  syy_q <= syy_q - sqext;
					SQ_OXY:  sxy_q <= sxy_q - sqext;
					SQ_NXX:  sxx_q <= sxx_q + sqext;
					SQ_NYY:  syy_q <= syy_q + sqext;
					SQ_NXY:  sxy_q <= sxy_q + sqext;
					default: ;
				endcase
			end
		end
	end

	assign sts.report = (cnt_q >= weff) || (partial_q && (cnt_q >= minsmp_q));

	// Sign and magnitude of the sums for the shared multiplier.
	logic signed [SUM_W-1:0] sx_abs, sy_abs;
	logic signed [SQ_W-1:0]  sxy_abs;
	logic                    sx_neg, sy_neg, sxy_neg;
	logic [LIMB_W-1:0]       sx_mag, sy_mag;

	assign sx_neg  = sx_q[SUM_W-1];
	assign sy_neg  = sy_q[SUM_W-1];
	assign sxy_neg = sxy_q[SQ_W-1];
	assign sx_abs  = sx_neg ? -sx_q : sx_q;
	assign sy_abs  = sy_neg ? -sy_q : sy_q;
	assign sxy_abs = sxy_neg ? -sxy_q : sxy_q;
	assign sx_mag  = sx_abs[LIMB_W-1:0];
	assign sy_mag  = sy_abs[LIMB_W-1:0];

	logic [MAG_W-1:0]  vx_q, vy_q, num_q;
	logic              vx_flat_q, vy_flat_q, num_neg_q;
	logic [PROD_W-1:0] p_q;
	logic [M_W-1:0]    m_q;
	logic [CNT_W-1:0]  n_v;

	assign n_v = cnt_q;

	// Operand selection of the shared 24 x 24 multiplier.
	logic [LIMB_W-1:0] ma, mb;
	logic [1:0]        msh;
	logic              mneg;

	always_comb begin
		ma   = LIMB_W'(n_v);
		mb   = '0;
		msh  = 2'd0;
		mneg = 1'b0;
		case (cmd.mac_op)
			MO_N_XXL: mb = sxx_q[LIMB_W-1:0];
			MO_N_XXH: begin
				mb  = LIMB_W'(sxx_q[SQ_W-2:LIMB_W]);
				msh = 2'd1;
			end
			MO_SX_SX: begin
				ma   = sx_mag;
				mb   = sx_mag;
				mneg = 1'b1;
			end
			MO_N_YYL: mb = syy_q[LIMB_W-1:0];
			MO_N_YYH: begin
				mb  = LIMB_W'(syy_q[SQ_W-2:LIMB_W]);
				msh = 2'd1;
			end
			MO_SY_SY: begin
				ma   = sy_mag;
				mb   = sy_mag;
				mneg = 1'b1;
			end
			MO_N_XYL: begin
				mb   = sxy_abs[LIMB_W-1:0];
				mneg = sxy_neg;
			end
			MO_N_XYH: begin
				mb   = LIMB_W'(sxy_abs[SQ_W-2:LIMB_W]);
				msh  = 2'd1;
				mneg = sxy_neg;
			end
			MO_SX_SY: begin
				ma   = sx_mag;
				mb   = sy_mag;
				mneg = ~(sx_neg ^ sy_neg);
			end
			MO_P_LL: begin
				ma = vx_q[LIMB_W-1:0];
				mb = vy_q[LIMB_W-1:0];
			end
			MO_P_LH: begin
				ma  = vx_q[LIMB_W-1:0];
				mb  = vy_q[MAG_W-1:LIMB_W];
				msh = 2'd1;
			end
			MO_P_HL: begin
				ma  = vx_q[MAG_W-1:LIMB_W];
				mb  = vy_q[LIMB_W-1:0];
				msh = 2'd1;
			end
			MO_P_HH: begin
				ma  = vx_q[MAG_W-1:LIMB_W];
				mb  = vy_q[MAG_W-1:LIMB_W];
				msh = 2'd2;
			end
			MO_M_LL: begin
				ma = num_q[LIMB_W-1:0];
				mb = num_q[LIMB_W-1:0];
			end
			MO_M_LH: begin
				ma  = num_q[LIMB_W-1:0];
				mb  = num_q[MAG_W-1:LIMB_W];
				msh = 2'd1;
			end
			MO_M_HL: begin
				ma  = num_q[MAG_W-1:LIMB_W];
				mb  = num_q[LIMB_W-1:0];
				msh = 2'd1;
			end
			MO_M_HH: begin
				ma  = num_q[MAG_W-1:LIMB_W];
				mb  = num_q[MAG_W-1:LIMB_W];
				msh = 2'd2;
			end
			default: ;
		endcase
	end

	// Product register, then shifted accumulate.
	logic [MAG_W-1:0] mprod_s1;
	logic [1:0]       msh_s1;
	logic             mneg_s1, mvld_s1;
	logic [ACC_W-1:0] acc_q, addend, acc_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_s1 <= 1'b0;
		end else begin
			mvld_s1 <= cmd.mac_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			mprod_s1 <= MAG_W'(ma) * MAG_W'(mb);
			msh_s1   <= msh;
			mneg_s1  <= mneg;
		end
	end

	always_comb begin
		case (msh_s1)
			2'd1:    addend = ACC_W'(mprod_s1) << LIMB_W;
			2'd2:    addend = ACC_W'(mprod_s1) << (2 * LIMB_W);
			default: addend = ACC_W'(mprod_s1);
		endcase
	end

	assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.store_en) begin
			acc_q <= '0;
		end else if (mvld_s1) begin
			acc_q <= mneg_s1 ? acc_q - addend : acc_q + addend;
		end
		if (cmd.store_en) begin
			case (cmd.store_dst)
				SD_VX: begin
					vx_q      <= acc_q[MAG_W-1:0];
					vx_flat_q <= acc_q[ACC_W-1] | (acc_q == '0);
				end
				SD_VY: begin
					vy_q      <= acc_q[MAG_W-1:0];
					vy_flat_q <= acc_q[ACC_W-1] | (acc_q == '0);
				end
				SD_NUM: begin
					num_neg_q <= acc_q[ACC_W-1];
					num_q     <= acc_abs[MAG_W-1:0];
				end
				SD_P:    p_q <= acc_q[PROD_W-1:0];
				SD_M:    m_q <= {acc_q[PROD_W-1:0], (2 * QB)'(0)};
				default: ;
			endcase
		end
	end

	// Root search, one result bit per try and decide pair.
	// a = p(2L-1)^2, bs = p(2L-1) 2^(b+2), ps = p 2^(2b+2) for result bit b.
	logic [M_W-1:0]   a_q;
	logic [TRY_W-1:0] bs_q, ps_q, trial_q, bs2_q, bsel;
	logic [QB-1:0]    root_q, bit_q;
	logic             ok;

	assign ok   = $signed(trial_q) <= $signed(TRY_W'(m_q));
	assign bsel = ok ? bs2_q : bs_q;

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			a_q    <= M_W'(p_q);
			bs_q   <= -(TRY_W'(p_q) << (QB + 1));
			ps_q   <= TRY_W'(p_q) << (2 * QB);
			root_q <= '0;
			bit_q  <= {1'b1, {(QB - 1){1'b0}}};
		end else if (cmd.srch_try) begin
			trial_q <= TRY_W'(a_q) + bs_q + ps_q;
			bs2_q   <= bs_q + (ps_q << 1);
		end else if (cmd.srch_dec) begin
			if (ok) begin
				a_q    <= trial_q[M_W-1:0];
				root_q <= root_q | bit_q;
			end
			bs_q  <= TRY_W'($signed(bsel) >>> 1);
			ps_q  <= ps_q >> 2;
			bit_q <= bit_q >> 1;
		end
	end

	// Output register.
	logic                 oval_q;
	logic signed [QB-1:0] corr_q;
	logic [1:0]           stat_q;

	assign sts.out_free = ~oval_q | ~out_stall;
	assign out_valid    = oval_q;
	assign correlation  = corr_q;
	assign status       = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.res_load) begin
			oval_q <= 1'b1;
		end else if (!out_stall) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (!sts.report) begin
				stat_q <= STAT_NONE;
				corr_q <= '0;
			end else if (vx_flat_q || vy_flat_q) begin
				stat_q <= STAT_FLAT;
				corr_q <= '0;
			end else begin
				stat_q <= STAT_VALID;
				if (num_neg_q) begin
					corr_q <= -$signed(root_q);
				end else if (root_q[QB-1]) begin
					corr_q <= {1'b0, {(QB - 1){1'b1}}};
				end else begin
					corr_q <= $signed(root_q);
				end
			end
		end
	end

endmodule

>>> src/sliding_window_correlation_top.sv
// Top level of the sliding window correlation block.
`timescale 1ns / 1ps
// Rolling Pearson correlation of two signed sample series.
// Input channel: in_valid / in_stall carry one beat of x_sample, y_sample
// and series_start; series_start clears the sums and history first.
// Output channel: out_valid / out_stall carry one beat of correlation (Q1.15)
// and status (0 none, 1 valid, 2 zero variance) for every input beat.
// Configuration: cfg_valid / cfg_ready write window_length (0),
// partial_mode (1) and min_samples (2); a window_length write clears the
// history and sums. Write only while the block is idle.
// A correlation is formed through the read, update, multiply and root
// search states; when the window has not yet answered, the multiply and
// search states are skipped. One item is in flight at a time; the next
// input beat is taken in the cycle after the result is loaded.
// The 16 bit root search, a try and a decide state per bit, and the 17
// partial products of the shared 24 x 24 multiplier set the rate.
// Reset loads window_length 20, partial_mode 0, min_samples 0 and empties
// the window; the history RAM needs no clearing pass.
// When the receiver stalls, the result beat holds and the sequencer waits
// at its last step until the output register is free.
module sliding_window_correlation_top import swc_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [SB-1:0] x_sample,
	input  logic signed [SB-1:0] y_sample,
	input  logic                 series_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [QB-1:0] correlation,
	output logic [1:0]           status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	swc_cmd_t cmd;
	swc_sts_t sts;

	swc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	swc_dp #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.series_start(series_start),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.correlation (correlation),
		.status      (status)
	);

endmodule

>>> sim/swc_checker.sv
// Checker that predicts and compares the correlation results of the block.
`timescale 1ns / 1ps
module swc_checker import swc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [SB-1:0] x_sample,
	input  logic signed [SB-1:0] y_sample,
	input  logic                 series_start,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [QB-1:0] correlation,
	input  logic [1:0]           status,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam int DEPTH = DEF_MAX_WINDOW;

	typedef struct {
		logic signed [QB-1:0] corr;
		logic [1:0]           stat;
	} result_t;

	// Mirror of the block's window, sums and registers.
	logic signed [SB-1:0] x_hist [DEPTH];
	logic signed [SB-1:0] y_hist [DEPTH];
	int          wr_ptr;
	int          seen;
	longint      sum_x, sum_y, sum_xx, sum_yy, sum_xy;
	logic [CFG_W-1:0] win_len;
	logic        partial;
	logic [CFG_W-1:0] min_cnt;
	result_t     expected_results [$];

	assign pending = expected_results.size();

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic void clear_window();
		for (int i = 0; i < DEPTH; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		wr_ptr = 0;
		seen = 0;
		sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
	endfunction

	function automatic int eff_window();
		if (win_len < 1) return 1;
		if (win_len > DEPTH) return DEPTH;
		return int'(win_len);
	endfunction

	// Exact Pearson correlation over the current sums, rounded into Q1.15.
	function automatic result_t correlate();
		result_t r;
		logic signed [127:0] nn, vx, vy, num, mg;
		logic [255:0] m, p, k, t;
		int lo, hi, mid;
		longint d;
		r.corr = '0;
		r.stat = STAT_FLAT;
		nn = 128'(seen);
		vx = nn * sum_xx - sum_x * sum_x;
		vy = nn * sum_yy - sum_y * sum_y;
		if (vx <= 0 || vy <= 0) return r;
		num = nn * sum_xy - sum_x * sum_y;
		mg = (num < 0) ? -num : num;
		m = 256'(mg);
		m = m << 16;
		m = m * m;
		p = 256'(vx);
		t = 256'(vy);
		p = p * t;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			d = 64'(2 * mid - 1);
			k = 256'(d);
			k = k * k;
			t = p * k;
			if (t <= m) lo = mid;
			else hi = mid - 1;
		end
		r.stat = STAT_VALID;
		if (num < 0) r.corr = QB'(-lo);
		else r.corr = (lo > 32767) ? 16'sd32767 : QB'(lo);
		return r;
	endfunction

	// One input beat: slide the window and work out the result it causes.
	function automatic result_t take_pair(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
			logic start);
		result_t r;
		int w, old;
		longint ox, oy, nx, ny;
		w = eff_window();
		if (start) clear_window();
		if (seen >= w) begin
			old = (wr_ptr + DEPTH - w) % DEPTH;
			ox = 64'(x_hist[old]);
			oy = 64'(y_hist[old]);
			sum_x -= ox; sum_y -= oy;
			sum_xx -= ox * ox; sum_yy -= oy * oy; sum_xy -= ox * oy;
			seen = w;
		end else begin
			seen++;
		end
		x_hist[wr_ptr] = x;
		y_hist[wr_ptr] = y;
		wr_ptr = (wr_ptr + 1) % DEPTH;
		nx = 64'(x);
		ny = 64'(y);
		sum_x += nx; sum_y += ny;
		sum_xx += nx * nx; sum_yy += ny * ny; sum_xy += nx * ny;
		r.corr = '0;
		r.stat = STAT_NONE;
		if (seen >= w || (partial && seen >= min_cnt)) r = correlate();
		return r;
	endfunction

	// Watch the three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			clear_window();
			win_len = CFG_W'(20);
			partial = 1'b0;
			min_cnt = '0;
			expected_results.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW: begin
						win_len = cfg_data;
						clear_window();
					end
					REG_PARTIAL: partial = cfg_data[0];
					REG_MIN: min_cnt = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.push_back(take_pair(x_sample, y_sample, series_start));
			if (out_valid && !out_stall) begin
				got.corr = correlation;
				got.stat = status;
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result beat corr %0d status %0d",
						correlation, status));
				end else begin
					want = expected_results.pop_front();
					if (got.stat !== want.stat)
						report($sformatf("status %0d, predicted %0d", got.stat, want.stat));
					if (got.corr !== want.corr)
						report($sformatf("correlation %0d, predicted %0d",
							got.corr, want.corr));
				end
			end
		end
	end

endmodule

>>> sim/tb_sliding_window_correlation_top.sv
// Stimulus and verdict for the sliding window correlation block.
`timescale 1ns / 1ps
module tb_sliding_window_correlation_top;
	import swc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SB-1:0] x_sample;
	logic signed [SB-1:0] y_sample;
	logic                 series_start;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [QB-1:0] correlation;
	logic [1:0]           status;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;

	int  tx_idle_pct;
	int  rx_idle_pct;
	bit  rx_hold;
	longint cycles;

	sliding_window_correlation_top uut (.*);

	swc_checker chk (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when asked.
	initial begin
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Sends one beat, sometimes after a random gap, and drops valid once it is taken.
	task automatic send_pair(input logic signed [SB-1:0] x, input logic signed [SB-1:0] y,
			input logic start);
		if ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		x_sample <= x;
		y_sample <= y;
		series_start <= start;
		#1;
		while (in_stall) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Lets every expected result drain before the next step.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		#1;
		while (!cfg_ready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input int wl, input int pm, input int ms);
		drain();
		write_reg(REG_PARTIAL, CFG_W'(pm));
		write_reg(REG_MIN, CFG_W'(ms));
		write_reg(REG_WINDOW, CFG_W'(wl));
	endtask

	// Random sample pair of one of several shapes.
	task automatic random_pair(output logic signed [SB-1:0] x,
			output logic signed [SB-1:0] y);
		int shape;
		shape = $urandom_range(9);
		x = SB'($urandom);
		case (shape)
			0, 1, 2: y = SB'($urandom);
			3, 4: y = SB'(x + $signed(SB'($urandom_range(64))) - 32);
			5: y = -x;
			6: begin
				x = SB'($signed(SB'($urandom_range(15))) - 8);
				y = SB'($signed(SB'($urandom_range(15))) - 8);
			end
			7: y = 16'sd1000;
			8: x = 16'sh7fff;
			default: y = x;
		endcase
	endtask

	initial begin
		logic signed [SB-1:0] xs, ys;
		int wl, pm, ms, count;
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_sample = '0;
		y_sample = '0;
		series_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_pct = 16;
		rx_idle_pct = 66;
		rx_hold = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: default registers, a short partial window, then window length 0.
		send_pair(16'sh7fff, -16'sh8000, 1'b0);
		send_pair(-16'sh8000, 16'sh7fff, 1'b0);
		set_mode(4, 1, 0);
		send_pair(-16'sh8000, 16'sh7fff, 1'b0);
		send_pair(16'sh7fff, -16'sh8000, 1'b0);
		send_pair(16'sh7fff, -16'sh8000, 1'b0);
		send_pair(-16'sh8000, -16'sh8000, 1'b0);
		send_pair(16'sh7fff, 16'sh7fff, 1'b0);
		send_pair(16'sd5, 16'sd5, 1'b1);
		send_pair(-16'sd7, -16'sd7, 1'b0);
		send_pair(16'sd9, 16'sd9, 1'b0);
		send_pair(16'sd3, -16'sd3, 1'b1);
		send_pair(-16'sd4, 16'sd4, 1'b0);
		send_pair(16'sd8, -16'sd8, 1'b0);
		send_pair(16'sd2, 16'sd2, 1'b1);
		send_pair(16'sd2, 16'sd2, 1'b0);
		send_pair(16'sd2, -16'sd9, 1'b0);
		send_pair(16'sd0, 16'sd0, 1'b0);
		send_pair(16'sd1, 16'sd3, 1'b0);
		send_pair(-16'sd1, 16'sd0, 1'b0);
		set_mode(0, 0, 0);
		send_pair(16'sd100, 16'sd3, 1'b0);
		send_pair(-16'sd100, 16'sd30, 1'b0);

		// Random phases across window settings and idling patterns.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin wl = 20; pm = 0; ms = 0; end
				1: begin wl = 256; pm = 1; ms = 256; end
				2: begin wl = 1; pm = 1; ms = 511; end
				3: begin wl = 511; pm = 1; ms = 3; end
				4: begin wl = 2; pm = 0; ms = 0; end
				5: begin wl = 256; pm = 0; ms = 0; end
				6: begin wl = 0; pm = 1; ms = 0; end
				7: begin wl = 8; pm = 1; ms = 6; end
				default: begin
					wl = $urandom_range(2, 40);
					pm = $urandom_range(1);
					ms = $urandom_range(wl);
				end
			endcase
			if (ph == 4) begin
				tx_idle_pct = 66;
				rx_idle_pct = 16;
			end else if (ph == 8) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_mode(wl, pm, ms);
			count = (wl >= 256) ? 240 : 100;
			for (int i = 0; i < count; i++) begin
				// Long receiver hold-off while the sender keeps offering.
				if (ph == 2 && i == 20) begin
					rx_hold = 1'b1;
					fork
						begin
							repeat (600) @(negedge clk);
							rx_hold = 1'b0;
						end
					join_none
				end
				random_pair(xs, ys);
				send_pair(xs, ys, $urandom_range(49) == 0);
			end
		end

		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
